/* hw/rtl/srt_pkg.sv */
package srt_pkg;

    localparam int ID_W     = 16;
    localparam int POSTAL_W = 20;
    localparam int HOUSE_W  = 14;
    localparam int BLOCK_W  = 10;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_LIST   = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    typedef struct packed {
        logic [POSTAL_W-1:0] postal;
        logic [HOUSE_W-1:0]  house;
        logic [BLOCK_W-1:0]  block;
        logic [ID_W-1:0]     id;
    } t_rec;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [POSTAL_W-1:0] postal_index;
        logic [HOUSE_W-1:0]  house_number;
        logic [BLOCK_W-1:0]  block_number;
        logic [ID_W-1:0]     query_id;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_W-1:0]     rec_id;
        logic [POSTAL_W-1:0] rec_postal_index;
        logic [HOUSE_W-1:0]  rec_house;
        logic [BLOCK_W-1:0]  rec_block;
        logic                last;
    } t_res;

    typedef struct packed {
        logic we;
        logic re;
        t_rec wdata;
    } t_mem_ctl;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_START,
        S_INS_CMP,
        S_INS_WR,
        S_FIND,
        S_DEL_RD,
        S_DEL_MV,
        S_LIST,
        S_EMIT
    } t_state;

endpackage

/* hw/rtl/srt_ifs.sv */
interface srt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [19:0] postal_index;
    logic [13:0] house_number;
    logic [9:0]  block_number;
    logic [15:0] query_id;

    modport source (
        output valid, req_type, postal_index, house_number, block_number, query_id,
        input  ready
    );
    modport sink (
        input  valid, req_type, postal_index, house_number, block_number, query_id,
        output ready
    );
endinterface

interface srt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] rec_id;
    logic [19:0] rec_postal_index;
    logic [13:0] rec_house;
    logic [9:0]  rec_block;
    logic        last;

    modport source (
        output valid, status, rec_id, rec_postal_index, rec_house, rec_block, last,
        input  ready
    );
    modport sink (
        input  valid, status, rec_id, rec_postal_index, rec_house, rec_block, last,
        output ready
    );
endinterface

/* hw/rtl/srt_mem.sv */
module srt_mem import srt_pkg::*; #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_rec              o_rdata
);

    t_rec mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_waddr] <= i_ctl.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/srt_ctrl.sv */
module srt_ctrl import srt_pkg::*; #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX_W       = 5,
    parameter int CNT_W       = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    srt_req_if.sink          i_req,
    output t_mem_ctl         o_mem,
    output logic [IDX_W-1:0] o_waddr,
    output logic [IDX_W-1:0] o_raddr,
    input  t_rec             i_rdata,
    input  logic             i_out_free,
    output t_out_beat        o_beat
);

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ID_W:0]    r_next_id, n_next_id;
    t_res             r_res, n_res;

    t_rec             new_rec;
    logic             goes_before;
    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W:0]   idx_p2;
    logic             is_full;

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        new_rec.postal = r_req.postal_index;
        new_rec.house  = r_req.house_number;
        new_rec.block  = r_req.block_number;
        new_rec.id     = r_next_id[ID_W-1:0];
        goes_before = (new_rec.postal != i_rdata.postal) ? (new_rec.postal < i_rdata.postal)
                                                         : (new_rec.id < i_rdata.id);
        idx_p1  = CNT_W'(r_idx) + CNT_W'(1);
        idx_p2  = (CNT_W+1)'(r_idx) + (CNT_W+1)'(2);
        is_full = (r_count >= CNT_W'(TABLE_DEPTH)) || r_next_id[ID_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_idx     = r_idx;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_res     = r_res;
        o_mem     = '0;
        o_waddr   = r_idx;
        o_raddr   = '0;
        o_beat    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req.req_type     = i_req.req_type;
                    n_req.postal_index = i_req.postal_index;
                    n_req.house_number = i_req.house_number;
                    n_req.block_number = i_req.block_number;
                    n_req.query_id     = i_req.query_id;
                    o_mem.re = 1'b1;
                    n_idx    = '0;
                    n_res    = '0;
                    n_res.last = 1'b1;
                    case (i_req.req_type)
                        REQ_INSERT: begin
                            if (is_full) begin
                                n_res.status = STAT_FULL;
                                n_state      = S_EMIT;
                            end else begin
                                n_idx   = r_count[IDX_W-1:0];
                                n_state = S_INS_START;
                            end
                        end
                        REQ_DELETE, REQ_LOOKUP: begin
                            if (r_count == '0) begin
                                n_res.status = STAT_EMPTY;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_res.status = STAT_EMPTY;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_LIST;
                            end
                        end
                    endcase
                end
            end

            S_INS_START: begin
                if (r_idx == '0) begin
                    o_mem.we    = 1'b1;
                    o_mem.wdata = new_rec;
                    n_state     = S_INS_WR;
                end else begin
                    o_mem.re = 1'b1;
                    o_raddr  = r_idx - IDX_W'(1);
                    n_state  = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                o_mem.we = 1'b1;
                if (goes_before) begin
                    o_mem.wdata = i_rdata;
                    n_idx       = r_idx - IDX_W'(1);
                    if (r_idx == IDX_W'(1)) begin
                        n_state = S_INS_WR;
                    end else begin
                        o_mem.re = 1'b1;
                        o_raddr  = r_idx - IDX_W'(2);
                    end
                end else begin
                    o_mem.wdata = new_rec;
                    n_state     = S_INS_WR;
                    o_mem.we    = 1'b1;
                end
            end

            S_INS_WR: begin
                o_mem.we          = 1'b1;
                o_mem.wdata       = new_rec;
                n_count           = r_count + CNT_W'(1);
                n_next_id         = r_next_id + (ID_W+1)'(1);
                n_res.status      = STAT_OK;
                n_res.rec_id      = new_rec.id;
                n_res.rec_postal_index = new_rec.postal;
                n_res.rec_house   = new_rec.house;
                n_res.rec_block   = new_rec.block;
                n_res.last        = 1'b1;
                n_state           = S_EMIT;
            end

            S_FIND: begin
                if (i_rdata.id == r_req.query_id) begin
                    n_res.status           = STAT_OK;
                    n_res.rec_id           = i_rdata.id;
                    n_res.rec_postal_index = i_rdata.postal;
                    n_res.rec_house        = i_rdata.house;
                    n_res.rec_block        = i_rdata.block;
                    n_res.last             = 1'b1;
                    n_state = (r_req.req_type == REQ_DELETE) ? S_DEL_RD : S_EMIT;
                end else if (idx_p1 == r_count) begin
                    n_res.status = STAT_NOT_FOUND;
                    n_res.rec_id = r_req.query_id;
                    n_state      = S_EMIT;
                end else begin
                    o_mem.re = 1'b1;
                    o_raddr  = idx_p1[IDX_W-1:0];
                    n_idx    = idx_p1[IDX_W-1:0];
                end
            end

            S_DEL_RD: begin
                if (idx_p1 < r_count) begin
                    o_mem.re = 1'b1;
                    o_raddr  = idx_p1[IDX_W-1:0];
                    n_state  = S_DEL_MV;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_EMIT;
                end
            end

            S_DEL_MV: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = i_rdata;
                n_idx       = idx_p1[IDX_W-1:0];
                if (idx_p2 < {1'b0, r_count}) begin
                    o_mem.re = 1'b1;
                    o_raddr  = idx_p2[IDX_W-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_EMIT;
                end
            end

            S_LIST: begin
                if (i_out_free) begin
                    o_beat.valid                = 1'b1;
                    o_beat.res.status           = STAT_OK;
                    o_beat.res.rec_id           = i_rdata.id;
                    o_beat.res.rec_postal_index = i_rdata.postal;
                    o_beat.res.rec_house        = i_rdata.house;
                    o_beat.res.rec_block        = i_rdata.block;
                    o_beat.res.last             = (idx_p1 == r_count);
                    if (idx_p1 == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        o_mem.re = 1'b1;
                        o_raddr  = idx_p1[IDX_W-1:0];
                        n_idx    = idx_p1[IDX_W-1:0];
                    end
                end
            end

            S_EMIT: begin
                if (i_out_free) begin
                    o_beat.valid = 1'b1;
                    o_beat.res   = r_res;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we && o_mem.re) |-> (o_waddr != o_raddr))
        else $error("read and write of the same entry in one cycle");

    a_count_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && n_count != r_count) |-> (n_state == S_EMIT))
        else $error("entry count changed outside request completion");

    a_beat_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_beat.valid |-> i_out_free)
        else $error("result beat pushed into an occupied output register");

endmodule

/* hw/rtl/sorted_record_table.sv */
// Insert: compares the new record with the stored ones from the end, shifting each
// larger one up; a full table answers STAT_FULL with no compare. Lookup scans records in
// order; delete scans, then moves each later record down; an empty table answers unscanned.
// List: one result per cycle while the output is taken, once the first record is read.
// Requests: one at a time; the record memory walk (one read, one write port) sets the rate.
// Reset (i_rst_n low, synchronous): table empty, next id zero, output idle.
module sorted_record_table import srt_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srt_req_if.sink    i_req,
    srt_res_if.source  o_res
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_mem_ctl         mem_ctl;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    t_rec             rdata;
    t_out_beat        beat;
    logic             out_free;

    logic             r_ovalid;
    t_res             r_out;

    srt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_mem      (mem_ctl),
        .o_waddr    (waddr),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .i_out_free (out_free),
        .o_beat     (beat)
    );

    srt_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_free = !r_ovalid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (beat.valid) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat.valid) begin
            r_out <= beat.res;
        end
    end

    assign o_res.valid            = r_ovalid;
    assign o_res.status           = r_out.status;
    assign o_res.rec_id           = r_out.rec_id;
    assign o_res.rec_postal_index = r_out.rec_postal_index;
    assign o_res.rec_house        = r_out.rec_house;
    assign o_res.rec_block        = r_out.rec_block;
    assign o_res.last             = r_out.last;

endmodule

/* test/tb_sorted_record_table.sv */
`timescale 1ns / 1ps

module tb_sorted_record_table;
    import srt_pkg::*;

    localparam int     DEPTH        = 32;
    localparam int     ID_SPACE     = 65536;
    localparam int     HALF_PERIOD  = 4;
    localparam int     TAIL_CYCLES  = 2 * DEPTH + 8;
    localparam int     HOLD_CYCLES  = 1000;
    localparam int     MAX_REPORTS  = 10;
    localparam int     RANDOM_ITEMS = 160;
    localparam longint CYCLE_LIMIT  = 5_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    srt_req_if req_bus ();
    srt_res_if res_bus ();

    sorted_record_table #(.TABLE_DEPTH(DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    t_rec        shadow_table [DEPTH];
    int          shadow_count   = 0;
    logic [16:0] shadow_next_id = '0;
    t_res        expected_results [$];

    int     error_count    = 0;
    longint cycle_count    = 0;
    logic   tight_mode     = 1'b0;
    logic   holding        = 1'b0;
    int     burst_left     = 0;
    int     ready_run_left = 0;
    logic   ready_level    = 1'b1;
    t_res   observed;
    t_res   wanted;
    event   hold_off_go;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic t_res make_result(logic [1:0] status, logic [ID_W-1:0] id,
                                         logic [POSTAL_W-1:0] postal,
                                         logic [HOUSE_W-1:0] house,
                                         logic [BLOCK_W-1:0] block, logic last);
        t_res res;
        res.status           = status;
        res.rec_id           = id;
        res.rec_postal_index = postal;
        res.rec_house        = house;
        res.rec_block        = block;
        res.last             = last;
        return res;
    endfunction

    function automatic t_req make_request(logic [1:0] kind, logic [POSTAL_W-1:0] postal,
                                          logic [HOUSE_W-1:0] house,
                                          logic [BLOCK_W-1:0] block,
                                          logic [ID_W-1:0] qid);
        t_req req;
        req.req_type     = kind;
        req.postal_index = postal;
        req.house_number = house;
        req.block_number = block;
        req.query_id     = qid;
        return req;
    endfunction

    function automatic bit goes_first(t_rec a, t_rec b);
        if (a.postal != b.postal) begin
            return a.postal < b.postal;
        end
        return a.id < b.id;
    endfunction

    function automatic void predict_results(t_req req);
        t_rec rec;
        int   pos;
        pos = -1;
        case (req.req_type)
            REQ_INSERT: begin
                if (shadow_count >= DEPTH || shadow_next_id >= ID_SPACE) begin
                    expected_results.push_back(make_result(STAT_FULL, '0, '0, '0, '0, 1'b1));
                end else begin
                    rec.postal = req.postal_index;
                    rec.house  = req.house_number;
                    rec.block  = req.block_number;
                    rec.id     = shadow_next_id[ID_W-1:0];
                    shadow_next_id++;
                    pos = shadow_count;
                    while (pos > 0 && goes_first(rec, shadow_table[pos-1])) begin
                        shadow_table[pos] = shadow_table[pos-1];
                        pos--;
                    end
                    shadow_table[pos] = rec;
                    shadow_count++;
                    expected_results.push_back(make_result(STAT_OK, rec.id, rec.postal,
                                                           rec.house, rec.block, 1'b1));
                end
            end
            REQ_LIST: begin
                if (shadow_count == 0) begin
                    expected_results.push_back(make_result(STAT_EMPTY, '0, '0, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        rec = shadow_table[i];
                        expected_results.push_back(make_result(STAT_OK, rec.id, rec.postal,
                                                               rec.house, rec.block,
                                                               i == shadow_count - 1));
                    end
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    expected_results.push_back(make_result(STAT_EMPTY, '0, '0, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        if (pos < 0 && shadow_table[i].id == req.query_id) begin
                            pos = i;
                        end
                    end
                    if (pos < 0) begin
                        expected_results.push_back(make_result(STAT_NOT_FOUND, req.query_id,
                                                               '0, '0, '0, 1'b1));
                    end else begin
                        rec = shadow_table[pos];
                        expected_results.push_back(make_result(STAT_OK, rec.id, rec.postal,
                                                               rec.house, rec.block, 1'b1));
                        if (req.req_type == REQ_DELETE) begin
                            for (int i = pos; i + 1 < shadow_count; i++) begin
                                shadow_table[i] = shadow_table[i+1];
                            end
                            shadow_count--;
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic logic [POSTAL_W-1:0] pick_postal();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return POSTAL_W'(999999);
            2, 3, 4: return POSTAL_W'($urandom_range(0, 3) * 250000);
            default: return POSTAL_W'($urandom_range(0, 999999));
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_query_id();
        if (shadow_count != 0 && $urandom_range(0, 9) != 0) begin
            return shadow_table[$urandom_range(0, shadow_count - 1)].id;
        end
        return ID_W'($urandom);
    endfunction

    function automatic t_req random_request(int insert_share);
        t_req req;
        int   kind;
        req.postal_index = pick_postal();
        req.house_number = HOUSE_W'($urandom_range(0, 9999));
        req.block_number = BLOCK_W'($urandom_range(0, 999));
        req.query_id     = pick_query_id();
        kind             = $urandom_range(0, 19);
        if ($urandom_range(0, 99) < insert_share) begin
            req.req_type = REQ_INSERT;
        end else if (kind < 8) begin
            req.req_type = REQ_DELETE;
        end else if (kind < 17) begin
            req.req_type = REQ_LOOKUP;
        end else begin
            req.req_type = REQ_LIST;
        end
        return req;
    endfunction

    function automatic string format_result(t_res r);
        return $sformatf("status=%0d id=%0d postal=%0d house=%0d block=%0d last=%0b",
                         r.status, r.rec_id, r.rec_postal_index, r.rec_house, r.rec_block,
                         r.last);
    endfunction

    function automatic void report_error(string msg);
        if (error_count < MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endfunction

    // hold valid across a burst; drop it only for a gap
    task automatic send_request(t_req req);
        if (!tight_mode && burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= req.req_type;
        req_bus.postal_index <= req.postal_index;
        req_bus.house_number <= req.house_number;
        req_bus.block_number <= req.block_number;
        req_bus.query_id     <= req.query_id;
        do @(posedge i_clk); while (!req_bus.ready);
        predict_results(req);
    endtask

    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_request(make_request(REQ_LIST, '0, '0, '0, '0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, '0));
        send_request(make_request(REQ_DELETE, '1, '1, '1, '1));
        wait_for_results();
    endtask

    task automatic test_directed_records();
        send_request(make_request(REQ_INSERT, '0, '0, '0, '0));
        send_request(make_request(REQ_INSERT, POSTAL_W'(999999), HOUSE_W'(9999),
                                  BLOCK_W'(999), '0));
        send_request(make_request(REQ_INSERT, POSTAL_W'(500000), HOUSE_W'(1234),
                                  BLOCK_W'(56), '1));
        send_request(make_request(REQ_INSERT, POSTAL_W'(500000), HOUSE_W'(4321),
                                  BLOCK_W'(65), '0));
        send_request(make_request(REQ_INSERT, '0, HOUSE_W'(9999), BLOCK_W'(999), '0));
        send_request(make_request(REQ_LIST, '0, '0, '0, '0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, ID_W'(3)));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, '1));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, ID_W'(5)));
        send_request(make_request(REQ_DELETE, POSTAL_W'(999999), HOUSE_W'(9999),
                                  BLOCK_W'(999), ID_W'(2)));
        send_request(make_request(REQ_DELETE, '0, '0, '0, ID_W'(2)));
        send_request(make_request(REQ_LIST, '0, '0, '0, '0));
        send_request(make_request(REQ_DELETE, '0, '0, '0, ID_W'(0)));
        send_request(make_request(REQ_DELETE, '0, '0, '0, ID_W'(1)));
        send_request(make_request(REQ_DELETE, '0, '0, '0, ID_W'(3)));
        send_request(make_request(REQ_LIST, '0, '0, '0, '0));
        send_request(make_request(REQ_DELETE, '0, '0, '0, ID_W'(4)));
        send_request(make_request(REQ_LIST, '0, '0, '0, '0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, ID_W'(4)));
        wait_for_results();
    endtask

    task automatic test_full_table();
        while (shadow_count < DEPTH) begin
            send_request(random_request(100));
        end
        send_request(random_request(100));
        send_request(make_request(REQ_LIST, '0, '0, '0, '0));
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, shadow_table[DEPTH-1].id));
        send_request(make_request(REQ_DELETE, '0, '0, '0, shadow_table[DEPTH/2].id));
        send_request(random_request(100));
        send_request(random_request(100));
        wait_for_results();
    endtask

    task automatic test_random_mix();
        int shares [3] = '{20, 60, 45};
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_request(random_request(shares[(n / 60) % 3]));
            if (n % 100 == 99) begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    task automatic test_backpressure();
        -> hold_off_go;
        for (int n = 0; n < 40; n++) begin
            send_request(random_request(50));
        end
        wait_for_results();
    endtask

    task automatic test_tight_stream();
        tight_mode <= 1'b1;
        while (shadow_count != 0) begin
            send_request(make_request(REQ_DELETE, '0, '0, '0, shadow_table[0].id));
        end
        for (int n = 0; n < 8; n++) begin
            send_request(random_request(100));
        end
        send_request(make_request(REQ_LOOKUP, '0, '0, '0, '1));
        send_request(make_request(REQ_DELETE, '0, '0, '0, '1));
        send_request(make_request(REQ_LIST, '0, '0, '0, '0));
        wait_for_results();
        tight_mode <= 1'b0;
        send_request(random_request(100));
        send_request(make_request(REQ_LIST, '0, '0, '0, '0));
        wait_for_results();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else if (holding) begin
            res_bus.ready <= 1'b0;
        end else if (tight_mode) begin
            res_bus.ready <= 1'b1;
        end else begin
            if (ready_run_left == 0) begin
                ready_level    = ($urandom_range(0, 3) != 0);
                ready_run_left = ready_level ? $urandom_range(1, 40) : $urandom_range(1, 8);
            end
            ready_run_left--;
            res_bus.ready <= ready_level;
        end
    end

    initial begin
        forever begin
            @(hold_off_go);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            observed.status           = res_bus.status;
            observed.rec_id           = res_bus.rec_id;
            observed.rec_postal_index = res_bus.rec_postal_index;
            observed.rec_house        = res_bus.rec_house;
            observed.rec_block        = res_bus.rec_block;
            observed.last             = res_bus.last;
            if (expected_results.size() == 0) begin
                report_error({"unexpected beat: ", format_result(observed)});
            end else begin
                wanted = expected_results.pop_front();
                if (observed.status !== wanted.status
                        || observed.rec_id !== wanted.rec_id
                        || observed.rec_postal_index !== wanted.rec_postal_index
                        || observed.rec_house !== wanted.rec_house
                        || observed.rec_block !== wanted.rec_block
                        || observed.last !== wanted.last) begin
                    report_error({"expected ", format_result(wanted),
                                  " got ", format_result(observed)});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sorted_record_table: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.req_type     <= REQ_INSERT;
        req_bus.postal_index <= '0;
        req_bus.house_number <= '0;
        req_bus.block_number <= '0;
        req_bus.query_id     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_directed_records();
        test_full_table();
        test_random_mix();
        test_backpressure();
        test_tight_stream();
        wait_for_results();
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_sorted_record_table: clean");
        end else begin
            $display("tb_sorted_record_table: errors");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/srt_pkg.sv
hw/rtl/srt_ifs.sv
hw/rtl/srt_mem.sv
hw/rtl/srt_ctrl.sv
hw/rtl/sorted_record_table.sv
test/tb_sorted_record_table.sv
